>>> hw/rtl/oot_pkg.sv
// shared constants and types for the oriented box overlap test
`timescale 1ns / 1ps
`default_nettype none

package oot_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int QUAT_WIDTH_DEF  = 16;
    localparam int CFG_IDX_W       = 3;
    // power of two so the queue pointers wrap on their own
    localparam int QUEUE_DEPTH     = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_CENTER_X = 3'd0,
        CFG_A_CENTER_Y = 3'd1,
        CFG_A_CENTER_Z = 3'd2,
        CFG_A_HALF_X   = 3'd3,
        CFG_A_HALF_Y   = 3'd4,
        CFG_A_HALF_Z   = 3'd5,
        CFG_A_ROTATION = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

>>> hw/rtl/oot_intf.sv
// channel interfaces: candidate box input, result output, configuration write
`timescale 1ns / 1ps
`default_nettype none

interface oot_in_if #(
    parameter int CW = 32,
    parameter int QW = 16
) ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] b_center_x;
    logic signed [CW-1:0] b_center_y;
    logic signed [CW-1:0] b_center_z;
    logic        [CW-2:0] b_half_x;
    logic        [CW-2:0] b_half_y;
    logic        [CW-2:0] b_half_z;
    logic signed [QW-1:0] b_quat_w;
    logic signed [QW-1:0] b_quat_x;
    logic signed [QW-1:0] b_quat_y;
    logic signed [QW-1:0] b_quat_z;

    modport source (output valid, b_center_x, b_center_y, b_center_z, b_half_x, b_half_y,
                    b_half_z, b_quat_w, b_quat_x, b_quat_y, b_quat_z, input ready);
    modport sink (input valid, b_center_x, b_center_y, b_center_z, b_half_x, b_half_y,
                  b_half_z, b_quat_w, b_quat_x, b_quat_y, b_quat_z, output ready);
endinterface

interface oot_out_if ();
    logic valid;
    logic ready;
    logic boxes_overlap;

    modport source (output valid, boxes_overlap, input ready);
    modport sink (input valid, boxes_overlap, output ready);
endinterface

interface oot_cfg_if #(
    parameter int DW = 64,
    parameter int IW = 3
) ();
    logic          valid;
    logic          ready;
    logic [IW-1:0] index;
    logic [DW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/oot_quat_mat.sv
// quaternion to rotation matrix, two stages: exact entries, then round and saturate
`timescale 1ns / 1ps
`default_nettype none

module oot_quat_mat
    import oot_pkg::*;
#(
    parameter int QW = QUAT_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [QW-1:0] i_q [4],
    output logic signed [QW:0]        o_m [3][3]
);

    localparam int F  = QW - 1;
    localparam int PW = 2 * QW + 3;
    localparam int RW = PW - F;
    localparam logic signed [PW-1:0] ONE  = PW'(1) <<< (2 * F);
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (F - 1);
    localparam logic signed [RW-1:0] SP   = RW'(1) <<< F;
    localparam logic signed [RW-1:0] SN   = -SP;

    logic signed [PW-1:0] w, x, y, z;
    logic signed [PW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic signed [PW-1:0] n_raw [3][3];
    logic signed [PW-1:0] r_raw [3][3];
    logic signed [QW:0]   n_m   [3][3];
    logic signed [QW:0]   r_m   [3][3];

    always_comb begin
        w  = PW'(i_q[0]);
        x  = PW'(i_q[1]);
        y  = PW'(i_q[2]);
        z  = PW'(i_q[3]);
        xx = x * x;
        yy = y * y;
        zz = z * z;
        xy = x * y;
        xz = x * z;
        yz = y * z;
        wx = w * x;
        wy = w * y;
        wz = w * z;
        n_raw[0][0] = ONE - ((yy + zz) <<< 1);
        n_raw[0][1] = (xy - wz) <<< 1;
        n_raw[0][2] = (xz + wy) <<< 1;
        n_raw[1][0] = (xy + wz) <<< 1;
        n_raw[1][1] = ONE - ((xx + zz) <<< 1);
        n_raw[1][2] = (yz - wx) <<< 1;
        n_raw[2][0] = (xz - wy) <<< 1;
        n_raw[2][1] = (yz + wx) <<< 1;
        n_raw[2][2] = ONE - ((xx + yy) <<< 1);
    end

    always_comb begin
        logic signed [PW-1:0] sum;
        logic signed [RW-1:0] rnd;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                sum = r_raw[i][j] + HALF;
                rnd = sum[PW-1:F];
                priority if (rnd > SP) begin
                    n_m[i][j] = (QW+1)'(SP);
                end else if (rnd < SN) begin
                    n_m[i][j] = (QW+1)'(SN);
                end else begin
                    n_m[i][j] = (QW+1)'(rnd);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_raw <= n_raw;
            r_m   <= n_m;
        end
    end

    assign o_m = r_m;

endmodule

`default_nettype wire

>>> hw/rtl/oot_front.sv
// front end: takes candidate words, forms the center offset, queues them
`timescale 1ns / 1ps
`default_nettype none

module oot_front
    import oot_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int QW = QUAT_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    oot_in_if.sink                    i_b,
    input  wire logic signed [CW-1:0] i_a_center [3],
    input  wire logic                 i_pop,
    output logic                      o_valid,
    output logic signed [CW:0]        o_d  [3],
    output logic        [CW-2:0]      o_hb [3],
    output logic signed [QW-1:0]      o_q  [4],
    output t_q_status                 o_status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic signed [CW:0]   r_qd  [QUEUE_DEPTH][3];
    logic        [CW-2:0] r_qhb [QUEUE_DEPTH][3];
    logic signed [QW-1:0] r_qq  [QUEUE_DEPTH][4];
    logic [PTR_W-1:0]     r_wr, r_rd;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 full, empty, push, pop;

    assign full   = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign empty  = (r_cnt == '0);
    assign push   = i_b.valid && !full;
    assign pop    = i_pop && !empty;
    assign i_b.ready = !full;

    always_comb begin
        n_cnt = r_cnt;
        priority if (push && !pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
        end
    end

    // offset of B from A's center, one bit wider so it never wraps
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_qd[r_wr][0]  <= (CW+1)'(i_b.b_center_x) - (CW+1)'(i_a_center[0]);
            r_qd[r_wr][1]  <= (CW+1)'(i_b.b_center_y) - (CW+1)'(i_a_center[1]);
            r_qd[r_wr][2]  <= (CW+1)'(i_b.b_center_z) - (CW+1)'(i_a_center[2]);
            r_qhb[r_wr][0] <= i_b.b_half_x;
            r_qhb[r_wr][1] <= i_b.b_half_y;
            r_qhb[r_wr][2] <= i_b.b_half_z;
            r_qq[r_wr][0]  <= i_b.b_quat_w;
            r_qq[r_wr][1]  <= i_b.b_quat_x;
            r_qq[r_wr][2]  <= i_b.b_quat_y;
            r_qq[r_wr][3]  <= i_b.b_quat_z;
        end
    end

    assign o_valid = !empty;
    assign o_d     = r_qd[r_rd];
    assign o_hb    = r_qhb[r_rd];
    assign o_q     = r_qq[r_rd];
    assign o_status.full  = full;
    assign o_status.empty = empty;

endmodule

`default_nettype wire

>>> hw/rtl/oot_back.sv
// back end: seven-stage pipeline that runs the fifteen axis tests
`timescale 1ns / 1ps
`default_nettype none

module oot_back
    import oot_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int QW = QUAT_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic signed [QW:0]   i_ra [3][3],
    input  wire logic        [CW-2:0] i_ha [3],
    input  wire logic                 i_q_valid,
    input  wire logic signed [CW:0]   i_q_d  [3],
    input  wire logic        [CW-2:0] i_q_hb [3],
    input  wire logic signed [QW-1:0] i_q_b  [4],
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_overlap
);

    localparam int F   = QW - 1;
    localparam int MW  = QW + 1;
    localparam int HW  = CW - 1;
    localparam int CAW = 2 * QW + 4;
    localparam int CRW = CAW - F;
    localparam int SW  = CW + QW + 4;
    localparam int TW  = SW - F;
    localparam int PTW = TW + MW;
    localparam int PHW = HW + 1 + MW;
    localparam int XW  = CW + QW + 10;
    localparam int NAX = 15;
    localparam logic signed [CAW-1:0] CHALF = CAW'(1) <<< (F - 1);
    localparam logic signed [SW-1:0]  SHALF = SW'(1) <<< (F - 1);
    localparam logic signed [CRW-1:0] SP    = CRW'(1) <<< F;
    localparam logic signed [CRW-1:0] SN    = -SP;

    logic en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;

    logic signed [CW:0]   r1_d [3], r2_d [3];
    logic        [HW-1:0] r1_hb [3], r2_hb [3], r3_hb [3], r4_hb [3], r5_hb [3];
    logic signed [MW-1:0] rb [3][3];

    logic signed [CAW-1:0] n3_acc [3][3], r3_acc [3][3];
    logic signed [SW-1:0]  n3_s [3], r3_s [3];

    logic signed [MW-1:0] n4_c [3][3], r4_c [3][3];
    logic signed [MW-1:0] n4_ca [3][3], r4_ca [3][3];
    logic signed [TW-1:0] n4_t [3], r4_t [3], r5_t [3];

    logic signed [PTW-1:0] n5_pt [3][3][3], r5_pt [3][3][3];
    logic signed [PHW-1:0] n5_pa [3][3][3], r5_pa [3][3][3];
    logic signed [PHW-1:0] n5_pb [3][3][3], r5_pb [3][3][3];

    logic signed [XW-1:0] n6_l [NAX], r6_l [NAX];
    logic signed [XW-1:0] n6_r [NAX], r6_r [NAX];

    logic n7_sep;
    logic r_overlap;

    // the whole pipe moves together whenever the result slot can take a word
    assign en    = !r_v7 || i_ready;
    assign o_pop = en && i_q_valid;

    oot_quat_mat #(.QW(QW)) u_bmat (
        .i_clk (i_clk),
        .i_en  (en),
        .i_q   (i_q_b),
        .o_m   (rb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_q_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    // relative rotation and offset in A's frame
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n3_acc[i][j] = '0;
                for (int k = 0; k < 3; k++) begin
                    n3_acc[i][j] = n3_acc[i][j] + CAW'(i_ra[k][i]) * CAW'(rb[k][j]);
                end
            end
            n3_s[i] = '0;
            for (int k = 0; k < 3; k++) begin
                n3_s[i] = n3_s[i] + SW'(i_ra[k][i]) * SW'(r2_d[k]);
            end
        end
    end

    // round back to matrix scale and to Q16.16
    always_comb begin
        logic signed [CAW-1:0] csum;
        logic signed [CRW-1:0] crnd;
        logic signed [SW-1:0]  ssum;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                csum = r3_acc[i][j] + CHALF;
                crnd = csum[CAW-1:F];
                priority if (crnd > SP) begin
                    n4_c[i][j] = MW'(SP);
                end else if (crnd < SN) begin
                    n4_c[i][j] = MW'(SN);
                end else begin
                    n4_c[i][j] = MW'(crnd);
                end
                n4_ca[i][j] = n4_c[i][j][MW-1] ? -n4_c[i][j] : n4_c[i][j];
            end
            ssum    = r3_s[i] + SHALF;
            n4_t[i] = ssum[SW-1:F];
        end
    end

    // all products the axis sums need
    always_comb begin
        for (int m = 0; m < 3; m++) begin
            for (int n = 0; n < 3; n++) begin
                for (int j = 0; j < 3; j++) begin
                    n5_pt[m][n][j] = PTW'(r4_t[m]) * PTW'(r4_c[n][j]);
                    n5_pa[m][n][j] = $signed({2'b00, i_ha[m]}) * PHW'(r4_ca[n][j]);
                    // hb_n times |c[m][j]|
                    n5_pb[m][n][j] = $signed({2'b00, r4_hb[n]}) * PHW'(r4_ca[m][j]);
                end
            end
        end
    end

    // projected offset and radii for each axis
    always_comb begin
        logic signed [XW-1:0] lv, rv;
        int i1, i2, j1, j2;
        for (int i = 0; i < 3; i++) begin
            lv = XW'(r5_t[i]) <<< F;
            rv = $signed({{(XW-HW){1'b0}}, i_ha[i]}) <<< F;
            for (int j = 0; j < 3; j++) begin
                rv = rv + XW'(r5_pb[i][j][j]);
            end
            n6_l[i] = lv[XW-1] ? -lv : lv;
            n6_r[i] = rv;
        end
        for (int j = 0; j < 3; j++) begin
            lv = '0;
            rv = $signed({{(XW-HW){1'b0}}, r5_hb[j]}) <<< F;
            for (int i = 0; i < 3; i++) begin
                lv = lv + XW'(r5_pt[i][i][j]);
                rv = rv + XW'(r5_pa[i][i][j]);
            end
            n6_l[3 + j] = lv[XW-1] ? -lv : lv;
            n6_r[3 + j] = rv;
        end
        for (int i = 0; i < 3; i++) begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int j = 0; j < 3; j++) begin
                j1 = (j + 1) % 3;
                j2 = (j + 2) % 3;
                lv = XW'(r5_pt[i2][i1][j]) - XW'(r5_pt[i1][i2][j]);
                rv = XW'(r5_pa[i1][i2][j]) + XW'(r5_pa[i2][i1][j])
                   + XW'(r5_pb[i][j1][j2]) + XW'(r5_pb[i][j2][j1]);
                n6_l[6 + 3 * i + j] = lv[XW-1] ? -lv : lv;
                n6_r[6 + 3 * i + j] = rv;
            end
        end
    end

    // strict compare, touching boxes still overlap
    always_comb begin
        n7_sep = 1'b0;
        for (int a = 0; a < NAX; a++) begin
            n7_sep = n7_sep | (r6_l[a] > r6_r[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d      <= i_q_d;
            r1_hb     <= i_q_hb;
            r2_d      <= r1_d;
            r2_hb     <= r1_hb;
            r3_acc    <= n3_acc;
            r3_s      <= n3_s;
            r3_hb     <= r2_hb;
            r4_c      <= n4_c;
            r4_ca     <= n4_ca;
            r4_t      <= n4_t;
            r4_hb     <= r3_hb;
            r5_pt     <= n5_pt;
            r5_pa     <= n5_pa;
            r5_pb     <= n5_pb;
            r5_t      <= r4_t;
            r5_hb     <= r4_hb;
            r6_l      <= n6_l;
            r6_r      <= n6_r;
            r_overlap <= !n7_sep;
        end
    end

    assign o_valid   = r_v7;
    assign o_overlap = r_overlap;

endmodule

`default_nettype wire

>>> hw/rtl/obb_pair_overlap_test.sv
// top level: oriented box pair overlap test against a fixed query box
//
//  channel  dir  handshake      word
//  i_b      in   valid/ready    candidate box: center, half extents, quaternion
//  o_res    out  valid/ready    boxes_overlap
//  i_cfg    in   valid/ready    register index and data, ready always high
//
// one candidate per cycle sustained while results are taken; an accepted word is
// written into the queue, then popped into the first of seven pipeline stages,
// and the result shows once the seventh stage loads.
// reset clears the queue and the pipeline valid bits; query box registers
// return to the identity pose with zero size. a stalled result freezes the
// whole back pipeline, and the four-word queue keeps taking words until full.
// the query matrix settles once a rotation write has passed the raw and rounded stages.
`timescale 1ns / 1ps
`default_nettype none

module obb_pair_overlap_test
    import oot_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int QUAT_WIDTH  = QUAT_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    oot_in_if.sink    i_b,
    oot_out_if.source o_res,
    oot_cfg_if.sink   i_cfg
);

    localparam int CW = COORD_WIDTH;
    localparam int QW = QUAT_WIDTH;

    logic signed [CW-1:0]   r_a_center [3];
    logic        [CW-2:0]   r_a_half   [3];
    logic        [4*QW-1:0] r_a_rot;
    logic signed [QW-1:0]   a_q [4];
    logic signed [QW:0]     ra [3][3];

    logic                 q_valid, q_pop;
    logic signed [CW:0]   q_d  [3];
    logic        [CW-2:0] q_hb [3];
    logic signed [QW-1:0] q_b  [4];
    t_q_status            q_status;
    logic                 cfg_we;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_center[0] <= '0;
            r_a_center[1] <= '0;
            r_a_center[2] <= '0;
            r_a_half[0]   <= '0;
            r_a_half[1]   <= '0;
            r_a_half[2]   <= '0;
            r_a_rot       <= {1'b0, {(QW-1){1'b1}}, {(3*QW){1'b0}}};
        end else if (cfg_we) begin
            unique case (i_cfg.index)
                CFG_A_CENTER_X: r_a_center[0] <= i_cfg.data[CW-1:0];
                CFG_A_CENTER_Y: r_a_center[1] <= i_cfg.data[CW-1:0];
                CFG_A_CENTER_Z: r_a_center[2] <= i_cfg.data[CW-1:0];
                CFG_A_HALF_X:   r_a_half[0]   <= i_cfg.data[CW-2:0];
                CFG_A_HALF_Y:   r_a_half[1]   <= i_cfg.data[CW-2:0];
                CFG_A_HALF_Z:   r_a_half[2]   <= i_cfg.data[CW-2:0];
                CFG_A_ROTATION: r_a_rot       <= i_cfg.data[4*QW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            a_q[k] = r_a_rot[(3-k)*QW +: QW];
        end
    end

    oot_quat_mat #(.QW(QW)) u_amat (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_q   (a_q),
        .o_m   (ra)
    );

    oot_front #(.CW(CW), .QW(QW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_b        (i_b),
        .i_a_center (r_a_center),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_d        (q_d),
        .o_hb       (q_hb),
        .o_q        (q_b),
        .o_status   (q_status)
    );

    oot_back #(.CW(CW), .QW(QW)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ra      (ra),
        .i_ha      (r_a_half),
        .i_q_valid (q_valid),
        .i_q_d     (q_d),
        .i_q_hb    (q_hb),
        .i_q_b     (q_b),
        .o_pop     (q_pop),
        .o_valid   (o_res.valid),
        .i_ready   (o_res.ready),
        .o_overlap (o_res.boxes_overlap)
    );

    // a full queue must hold off the source
    a_full_blocks: assert property (@(posedge i_clk)
        q_status.full |-> !i_b.ready)
        else $error("input taken while queue full");

    // an accepted word is in the queue on the next cycle
    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_b.valid && i_b.ready) |=> !q_status.empty)
        else $error("accepted word lost");

    // reset leaves the queue empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> q_status.empty && !q_status.full)
        else $error("queue not cleared by reset");

    // the queue is never flagged full and empty at once
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue flags inconsistent");

endmodule

`default_nettype wire
